[hdl/lsej_pkg.sv]
`timescale 1ns / 1ps
// Package for the line sensor error and junction block.
// Holds shared types, register indexes, reset values and constant tables; no dependencies.

package lsej_pkg;

	localparam int NUM_SENSORS = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int QPROD_W     = 27;

	localparam logic [4:0] LEFT_PAIR  = 5'b11000;
	localparam logic [4:0] RIGHT_PAIR = 5'b00011;

	localparam logic signed [7:0] ANGLE_NONE  = 8'sd0;
	localparam logic signed [7:0] ANGLE_LEFT  = 8'sd90;
	localparam logic signed [7:0] ANGLE_RIGHT = -8'sd90;

	// Reset values of the configuration registers
	localparam logic       RST_ACTIVE_LOW = 1'b1;
	localparam logic [3:0] RST_CONFIRM    = 4'd3;
	localparam logic [3:0] RST_CLEAR      = 4'd5;
	localparam logic [7:0] RST_SCALE      = 8'd75;

	// Weight of each sensor, indexed by bit number (bit 0 is right outer)
	localparam logic signed [2:0] SENSOR_WEIGHT [NUM_SENSORS] = '{
		3'sd2, 3'sd1, 3'sd0, -3'sd1, -3'sd2
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_LOW = 3'd0,
		REG_CONFIRM    = 3'd1,
		REG_CLEAR      = 3'd2,
		REG_SCALE      = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic       active_low;
		logic [3:0] confirm;
		logic [3:0] clear;
		logic [7:0] scale;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic div;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	// ceil(2^RECIP_SHIFT / count): exact quotient for dividends below 1024
	function automatic logic [RECIP_W-1:0] recip(input logic [2:0] count);
		logic [RECIP_W-1:0] r;
		case (count)
			3'd1:    r = 17'd65536;
			3'd2:    r = 17'd32768;
			3'd3:    r = 17'd21846;
			3'd4:    r = 17'd16384;
			3'd5:    r = 17'd13108;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [7:0] junction_angle(input logic [4:0] act);
		logic left_hit;
		logic right_hit;
		left_hit  = (act & LEFT_PAIR) == LEFT_PAIR;
		right_hit = (act & RIGHT_PAIR) == RIGHT_PAIR;
		if (left_hit && !right_hit) begin
			return ANGLE_LEFT;
		end else if (right_hit && !left_hit) begin
			return ANGLE_RIGHT;
		end
		return ANGLE_NONE;
	endfunction

endpackage

[hdl/lsej_in_if.sv]
`timescale 1ns / 1ps
// Sample channel: one set of raw sensor pin levels per item.
// Stand-alone interface, no dependencies.

interface lsej_in_if ();
	logic       valid;
	logic       ready;
	logic [4:0] pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink (input valid, input pin_levels, output ready);
endinterface

[hdl/lsej_out_if.sv]
`timescale 1ns / 1ps
// Result channel: active pattern, position error, line flag and turn angle.
// Stand-alone interface, no dependencies.

interface lsej_out_if ();
	logic              valid;
	logic              ready;
	logic [4:0]        active_bits;
	logic signed [9:0] position_error;
	logic              line_valid;
	logic signed [7:0] turn_angle;

	modport source (output valid, output active_bits, output position_error,
		output line_valid, output turn_angle, input ready);
	modport sink (input valid, input active_bits, input position_error,
		input line_valid, input turn_angle, output ready);
endinterface

[hdl/lsej_cfg_if.sv]
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on lsej_pkg for the index width.

interface lsej_cfg_if import lsej_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [7:0]           wdata;

	modport source (output valid, output idx, output wdata, input ready);
	modport sink (input valid, input idx, input wdata, output ready);
endinterface

[hdl/lsej_dp.sv]
`timescale 1ns / 1ps
// Datapath: polarity, weighted sum, scale, reciprocal divide, turn state, output register.
// Depends on lsej_pkg; driven by lsej_ctrl commands.

module lsej_dp import lsej_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	output status_t           sts,
	input  logic [4:0]        pin_levels,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [4:0]        active_bits,
	output logic signed [9:0] position_error,
	output logic              line_valid,
	output logic signed [7:0] turn_angle
);

	logic [4:0]          act_c;
	logic signed [2:0]   sum_c;
	logic [2:0]          cnt_c;
	logic [4:0]          act_q;
	logic signed [2:0]   sum_q;
	logic [2:0]          cnt_q;
	logic signed [2:0]   sum_neg;
	logic [1:0]          mag;
	logic                neg_q;
	logic [9:0]          prod_q;
	logic [QPROD_W-1:0]  qprod_c;
	logic [9:0]          quot_q;
	logic [9:0]          quot_neg;
	logic signed [9:0]   err_c;

	logic                armed_q, pending_q;
	logic signed [7:0]   pangle_q;
	logic [3:0]          confirm_q, clear_q;
	logic signed [9:0]   held_q;
	logic                armed_n, pending_n;
	logic signed [7:0]   pangle_n, emit_n, angle_c;
	logic [3:0]          confirm_n, clear_n;
	logic                valid_c;
	logic                out_valid_q;

	// Polarity and weighted sum of the incoming sample
	always_comb begin
		act_c = cfg.active_low ? ~pin_levels : pin_levels;
		sum_c = '0;
		cnt_c = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (act_c[i]) begin
				sum_c = sum_c + SENSOR_WEIGHT[i];
				cnt_c = cnt_c + 3'd1;
			end
		end
	end

	assign sum_neg = -sum_q;
	assign mag     = sum_q[2] ? sum_neg[1:0] : sum_q[1:0];
	assign qprod_c = QPROD_W'(prod_q) * QPROD_W'(recip(cnt_q));
	assign quot_neg = -quot_q;
	assign err_c   = neg_q ? $signed(quot_neg) : $signed(quot_q);
	assign valid_c = cnt_q != 3'd0;
	assign angle_c = junction_angle(act_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= act_c;
			sum_q <= sum_c;
			cnt_q <= cnt_c;
		end
		if (cmd.mul) begin
			prod_q <= 10'(mag) * 10'(cfg.scale);
			neg_q  <= sum_q[2];
		end
		if (cmd.div) begin
			quot_q <= qprod_c[RECIP_SHIFT+9:RECIP_SHIFT];
		end
	end

	// Junction confirm / clear counters and pending turn
	always_comb begin
		armed_n   = armed_q;
		pending_n = pending_q;
		pangle_n  = pangle_q;
		confirm_n = confirm_q;
		clear_n   = clear_q;
		emit_n    = ANGLE_NONE;
		if (angle_c == ANGLE_NONE) begin
			confirm_n = '0;
			if (clear_q < cfg.clear) begin
				clear_n = clear_q + 4'd1;
			end
			if (clear_n >= cfg.clear) begin
				armed_n = 1'b1;
			end
		end else begin
			clear_n = '0;
			if (armed_q && !pending_q) begin
				if (confirm_q < cfg.confirm) begin
					confirm_n = confirm_q + 4'd1;
				end
				if (confirm_n >= cfg.confirm) begin
					pending_n = 1'b1;
					armed_n   = 1'b0;
					pangle_n  = angle_c;
				end
			end
		end
		// Emit the pending turn once the line is lost
		if (pending_n && !valid_c) begin
			emit_n    = pangle_n;
			pending_n = 1'b0;
			pangle_n  = ANGLE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b1;
			pending_q   <= 1'b0;
			pangle_q    <= ANGLE_NONE;
			confirm_q   <= '0;
			clear_q     <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				armed_q   <= armed_n;
				pending_q <= pending_n;
				pangle_q  <= pangle_n;
				confirm_q <= confirm_n;
				clear_q   <= clear_n;
				if (valid_c) begin
					held_q <= err_c;
				end
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			active_bits    <= act_q;
			position_error <= valid_c ? err_c : held_q;
			line_valid     <= valid_c;
			turn_angle     <= emit_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

[hdl/lsej_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences load, multiply, divide and commit for one item.
// Depends on lsej_pkg for the command and status types.

module lsej_ctrl import lsej_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_WB   = 4'b1000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_n = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				state_n = S_WB;
			end
			S_WB: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

`ifndef SYNTHESIS
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free) else $error("commit with output register full");
	a_load_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.mul) else $error("load not followed by multiply");
	a_mul_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |=> cmd.div) else $error("multiply not followed by divide");
	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.mul || cmd.div || cmd.commit))
		else $error("input ready while an item is in flight");
`endif

endmodule

[hdl/line_sensor_error_and_junction.sv]
`timescale 1ns / 1ps
// Line sensor position error and junction turn detector, top level.
// Depends on lsej_pkg, the three channel interfaces, lsej_ctrl and lsej_dp.
//
// Usage:
//   samp : one item carries five raw pin levels (bit 4 left outer .. bit 0 right outer).
//   res  : one item per sample: active pattern, position error (held while no
//          sensor is active), line flag, and turn angle (+90 / -90 emitted once
//          on the first sample after a confirmed junction where the line is lost).
//   cfg  : register writes, always ready; write only while the block is idle.
//          Index 0 polarity, 1 confirm count, 2 clear count, 3 error scale.
// Sequence:
//   An item is taken in the idle state, multiplied by the scale in the next
//   cycle, divided by the active count through a reciprocal multiply in the
//   cycle after, and committed to the output register in the write-back state
//   once that register is free. A new item is taken only after the previous
//   one is committed; the multiply and reciprocal steps share one sequence.
// Reset:
//   arst_n clears the turn state, the held error and the output valid flag,
//   and loads the register reset values (active low, 3, 5, 75).
// Stall:
//   If res is not taken, the next item is still accepted and worked on; its
//   commit waits until the output register frees, then samp.ready returns.

module line_sensor_error_and_junction import lsej_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	lsej_cfg_if.sink   cfg,
	lsej_in_if.sink    samp,
	lsej_out_if.source res
);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t sts;
	logic    cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	// Configuration register file; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low <= RST_ACTIVE_LOW;
			cfg_q.confirm    <= RST_CONFIRM;
			cfg_q.clear      <= RST_CLEAR;
			cfg_q.scale      <= RST_SCALE;
		end else if (cfg_we) begin
			case (cfg.idx)
				REG_ACTIVE_LOW: cfg_q.active_low <= cfg.wdata[0];
				REG_CONFIRM:    cfg_q.confirm    <= cfg.wdata[3:0];
				REG_CLEAR:      cfg_q.clear      <= cfg.wdata[3:0];
				REG_SCALE:      cfg_q.scale      <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	lsej_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samp.valid),
		.in_ready (samp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsej_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.sts            (sts),
		.pin_levels     (samp.pin_levels),
		.out_ready      (res.ready),
		.out_valid      (res.valid),
		.active_bits    (res.active_bits),
		.position_error (res.position_error),
		.line_valid     (res.line_valid),
		.turn_angle     (res.turn_angle)
	);

endmodule

[tb/sv/tb_line_sensor_error_and_junction.sv]
`timescale 1ns / 1ps
// Testbench for line_sensor_error_and_junction: directed and random sensor samples,
// each result checked against a local predictor. Depends on lsej_pkg and the channel interfaces.

module tb_line_sensor_error_and_junction import lsej_pkg::*;;

	// One expected result item, at the widths of the result channel
	typedef struct {
		logic [4:0]        active_bits;
		logic signed [9:0] position_error;
		logic              line_valid;
		logic signed [7:0] turn_angle;
	} sample_result_t;

	localparam int         NUM_PHASES   = 8;
	localparam int         PHASE_ITEMS  = 125;
	localparam int         DRAIN_CYCLES = 10;   // settle margin once all results are back
	localparam int         LONG_HOLD    = 200;  // long enough to back up the sample channel
	localparam int         MAX_REPORTS  = 10;
	localparam logic [4:0] NO_SENSORS   = 5'b00000;

	logic clk = 1'b0;
	logic arst_n;

	lsej_cfg_if cfg_ch ();
	lsej_in_if  samp_ch ();
	lsej_out_if res_ch ();

	line_sensor_error_and_junction dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.samp   (samp_ch),
		.res    (res_ch)
	);

	// Predictor copy of the registers and the turn state
	cfg_t              cur_cfg;
	logic              turn_armed;
	logic              turn_pending;
	logic signed [7:0] pending_turn;
	logic [3:0]        confirm_run;
	logic [3:0]        clear_run;
	logic signed [9:0] last_error;

	logic [4:0]     sample_queue [$];      // pin levels waiting to be offered
	sample_result_t expected_results [$];  // predicted results, oldest first
	int             mismatches = 0;
	bit             sender_gaps_on;
	bit             receiver_stalls_on;
	int             hold_requests = 0;      // bump to ask the receiver for a long hold-off

	int send_gap;
	int recv_stall;
	int hold_left;
	int hold_served;

	always #5 clk = ~clk;

	// Idle length: mostly none, often short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Advance the predictor by one accepted sample and return the result it must produce
	function automatic sample_result_t predict_sample(input logic [4:0] pins);
		sample_result_t    r;
		logic [4:0]        act;
		int                weighted;
		int                hits;
		int                b;
		logic signed [7:0] branch;
		act      = cur_cfg.active_low ? ~pins : pins;
		weighted = 0;
		hits     = 0;
		// bit 0 is right outer (+2), bit 4 is left outer (-2)
		for (b = 0; b < NUM_SENSORS; b++) begin
			if (act[b]) begin
				weighted += 2 - b;
				hits++;
			end
		end
		// SystemVerilog integer division truncates toward zero, as required
		if (hits > 0) begin
			last_error = 10'((weighted * int'(cur_cfg.scale)) / hits);
		end
		// One pair of a side fully lit while the other pair is not: junction
		branch = ANGLE_NONE;
		if (act[4] && act[3] && !(act[1] && act[0])) begin
			branch = ANGLE_LEFT;
		end else if (act[1] && act[0] && !(act[4] && act[3])) begin
			branch = ANGLE_RIGHT;
		end
		if (branch == ANGLE_NONE) begin
			confirm_run = '0;
			if (clear_run < cur_cfg.clear) begin
				clear_run++;
			end
			if (clear_run >= cur_cfg.clear) begin
				turn_armed = 1'b1;
			end
		end else begin
			clear_run = '0;
			if (turn_armed && !turn_pending) begin
				if (confirm_run < cur_cfg.confirm) begin
					confirm_run++;
				end
				if (confirm_run >= cur_cfg.confirm) begin
					turn_pending = 1'b1;
					turn_armed   = 1'b0;
					pending_turn = branch;
				end
			end
		end
		// A latched turn goes out once, on the first sample with the line lost
		r.turn_angle = ANGLE_NONE;
		if (turn_pending && hits == 0) begin
			r.turn_angle = pending_turn;
			turn_pending = 1'b0;
			pending_turn = ANGLE_NONE;
		end
		r.active_bits    = act;
		r.position_error = last_error;
		r.line_valid     = hits > 0;
		return r;
	endfunction

	// Queue a sample given as an active pattern, under the current polarity
	function automatic void push_active(input logic [4:0] act);
		sample_queue.push_back(cur_cfg.active_low ? ~act : act);
	endfunction

	// Queue one stretch of stimulus and return how many items it holds.
	// Most stretches follow a turn: junction run, line lost, plain line to re-arm.
	// Run lengths straddle the confirm and clear counts so that both latch and
	// fall short. The rest is raw noise on the pins.
	function automatic int queue_sequence();
		int         kind;
		int         n;
		int         i;
		int         pushed;
		logic [4:0] act;
		logic [1:0] other;
		pushed = 0;
		kind   = $urandom_range(0, 9);
		if (kind < 7) begin
			n = $urandom_range(0, cur_cfg.confirm + 2);
			for (i = 0; i < n; i++) begin
				other = 2'($urandom_range(0, 2));  // never the full opposite pair
				if (kind[0]) begin
					act = {2'b11, 1'($urandom), other};
				end else begin
					act = {other, 1'($urandom), 2'b11};
				end
				push_active(act);
			end
			pushed += n;
			n = $urandom_range(1, 3);
			for (i = 0; i < n; i++) begin
				push_active(NO_SENSORS);
			end
			pushed += n;
			n = $urandom_range(0, cur_cfg.clear + 2);
			for (i = 0; i < n; i++) begin
				// line present, no junction: both pairs lit or neither
				do begin
					act = 5'($urandom);
				end while (act == NO_SENSORS || (act[4] && act[3]) != (act[1] && act[0]));
				push_active(act);
			end
			pushed += n;
		end else begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) begin
				sample_queue.push_back(5'($urandom));
			end
			pushed += n;
		end
		return pushed;
	endfunction

	// Directed opening under reset polarity: field extremes, every single
	// sensor, a left turn emitted on line loss, re-arm, a right turn through
	// patterns with the center or a stray outer bit, then both pairs lit and a left pair while disarmed.
	function automatic void queue_directed();
		logic [4:0] opening [] = '{
			5'b11111, 5'b00000, 5'b10000, 5'b01000, 5'b00100, 5'b00010, 5'b00001,
			5'b11000, 5'b11000, 5'b11000, 5'b00000,
			5'b01110, 5'b01110, 5'b01110, 5'b01110,
			5'b00011, 5'b10111, 5'b00111, 5'b00000,
			5'b11011, 5'b11100, 5'b00000
		};
		foreach (opening[i]) begin
			push_active(opening[i]);
		end
	endfunction

	// Hold until every queued item is taken and every result is back, then
	// let the pipeline settle. Checked on the falling edge to stay clear of
	// the driver's updates at the rising edge.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (sample_queue.size() != 0 || samp_ch.valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four registers back to back; keep valid high across them
	task automatic write_settings(input cfg_t s);
		cfg_reg_t order [4];
		int       i;
		order = '{REG_ACTIVE_LOW, REG_CONFIRM, REG_CLEAR, REG_SCALE};
		@(posedge clk);
		for (i = 0; i < 4; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.idx   <= order[i];
			case (order[i])
				REG_ACTIVE_LOW: begin
					cfg_ch.wdata <= {7'd0, s.active_low};
				end
				REG_CONFIRM: begin
					cfg_ch.wdata <= {4'd0, s.confirm};
				end
				REG_CLEAR: begin
					cfg_ch.wdata <= {4'd0, s.clear};
				end
				default: begin
					cfg_ch.wdata <= s.scale;
				end
			endcase
			do begin
				@(posedge clk);
			end while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		cur_cfg = s;
	endtask

	// Sample driver: offer the next queued item once the current one is taken,
	// with random gaps between items. Predict each item as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_ch.valid      <= 1'b0;
			samp_ch.pin_levels <= '0;
			send_gap           <= 0;
		end else begin
			if (samp_ch.valid && samp_ch.ready) begin
				expected_results.push_back(predict_sample(samp_ch.pin_levels));
			end
			if (!samp_ch.valid || samp_ch.ready) begin
				if (send_gap > 0) begin
					samp_ch.valid <= 1'b0;
					send_gap      <= send_gap - 1;
				end else if (sample_queue.size() > 0) begin
					samp_ch.valid      <= 1'b1;
					samp_ch.pin_levels <= sample_queue.pop_front();
					send_gap           <= sender_gaps_on ? pick_gap() : 0;
				end else begin
					samp_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each taken item against the oldest prediction,
	// and drive ready with random stalls plus the long hold-off on request.
	always @(posedge clk or negedge arst_n) begin : result_check
		sample_result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_stall   <= 0;
			hold_left    <= 0;
			hold_served  <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("unexpected result: act %b err %0d line %b turn %0d",
							res_ch.active_bits, res_ch.position_error,
							res_ch.line_valid, res_ch.turn_angle);
					end
				end else begin
					want = expected_results.pop_front();
					if (res_ch.active_bits !== want.active_bits
						|| res_ch.position_error !== want.position_error
						|| res_ch.line_valid !== want.line_valid
						|| res_ch.turn_angle !== want.turn_angle) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("mismatch: expected act %b err %0d line %b turn %0d",
								want.active_bits, want.position_error,
								want.line_valid, want.turn_angle);
							$display("          got      act %b err %0d line %b turn %0d",
								res_ch.active_bits, res_ch.position_error,
								res_ch.line_valid, res_ch.turn_angle);
						end
					end
				end
			end
			if (hold_served != hold_requests) begin
				hold_served  <= hold_requests;
				hold_left    <= LONG_HOLD;
				res_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left    <= hold_left - 1;
				res_ch.ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall   <= recv_stall - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (receiver_stalls_on && $urandom_range(0, 99) < 20) begin
					recv_stall <= pick_gap();
				end
			end
		end
	end

	// Stimulus sequence: reset, directed opening, then one random phase per
	// register setting. Phase 1 holds the receiver off while the sender never
	// idles; phase 3 pauses the sender halfway until all results are back;
	// phase 5 runs the receiver without stalls.
	initial begin
		cfg_t phase_cfg [NUM_PHASES];
		int   ph;
		int   k;
		bit   paused;

		arst_n             = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.idx         = REG_ACTIVE_LOW;
		cfg_ch.wdata       = '0;
		sender_gaps_on     = 1'b1;
		receiver_stalls_on = 1'b1;

		cur_cfg      = '{RST_ACTIVE_LOW, RST_CONFIRM, RST_CLEAR, RST_SCALE};
		turn_armed   = 1'b1;
		turn_pending = 1'b0;
		pending_turn = ANGLE_NONE;
		confirm_run  = '0;
		clear_run    = '0;
		last_error   = '0;

		// reset values, then extremes with zero counts included, two middle settings and two random ones
		phase_cfg[0] = cur_cfg;
		phase_cfg[1] = '{1'b0, 4'd1, 4'd1, 8'd255};
		phase_cfg[2] = '{1'b1, 4'd15, 4'd15, 8'd0};
		phase_cfg[3] = '{1'b0, 4'd0, 4'd0, 8'd128};
		phase_cfg[4] = '{1'b1, 4'd2, 4'd4, 8'd1};
		phase_cfg[5] = '{1'b0, 4'd7, 4'd3, 8'd200};
		for (ph = 6; ph < NUM_PHASES; ph++) begin
			phase_cfg[ph] = '{1'($urandom), 4'($urandom), 4'($urandom), 8'($urandom)};
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				wait_drained();
				write_settings(phase_cfg[ph]);
			end else begin
				queue_directed();
			end
			sender_gaps_on     = (ph != 1);
			receiver_stalls_on = (ph != 5);
			if (ph == 1) begin
				hold_requests++;
			end
			k      = 0;
			paused = 1'b0;
			while (k < PHASE_ITEMS) begin
				k += queue_sequence();
				if (ph == 3 && !paused && k >= PHASE_ITEMS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
			end
		end

		wait_drained();
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
hdl/lsej_pkg.sv
hdl/lsej_in_if.sv
hdl/lsej_out_if.sv
hdl/lsej_cfg_if.sv
hdl/lsej_dp.sv
hdl/lsej_ctrl.sv
hdl/line_sensor_error_and_junction.sv
tb/sv/tb_line_sensor_error_and_junction.sv
